>>> src/kat_pkg.sv
// ----------------------------------------------------------------------------
// kat_pkg
// shared types and codes for the keyed accumulate table
// ----------------------------------------------------------------------------
package kat_pkg;

    localparam int KEY_W    = 16;
    localparam int QTY_IN_W = 16;
    localparam int QTY_W    = 24;
    localparam int PRICE_W  = 16;
    localparam int STATUS_W = 3;
    localparam int OUT_CNT_W = 5;

    // request codes
    localparam logic REQ_ADD = 1'b0;
    localparam logic REQ_DEL = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_MERGED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_APPENDED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [QTY_W-1:0]   qty;
        logic [PRICE_W-1:0] price;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic                load_req;
        logic                clr_idx;
        logic                inc_idx;
        logic                rd_en;
        logic                rd_next;
        logic                wr_merge;
        logic                wr_append;
        logic                wr_shift;
        logic                cnt_inc;
        logic                cnt_dec;
        logic                set_status;
        logic [STATUS_W-1:0] status;
        logic                out_load;
    } t_ctl_cmd;

    // datapath to controller
    typedef struct packed {
        logic req_type;
        logic at_end;
        logic key_match;
        logic full;
        logic shift_last;
        logic out_free;
    } t_ctl_sts;

endpackage

>>> src/keyed_accumulate_table.sv
// ----------------------------------------------------------------------------
// keyed_accumulate_table
// ordered key table with merge, append and delete-with-shift
// ----------------------------------------------------------------------------
// usage
//   input channel (i_valid / o_ready): one request per handshake, add or
//   delete selected by i_req_type, with key, quantity and price
//   output channel (o_valid / i_ready): one result per request, a status
//   code and the entry count after the request
//   scan: a request reads the table entry by entry, entries are
//   held in a single-port-read memory with registered read data
//     merge    : scan up to the matching entry, then write it back merged
//     append / full / not found : scan every entry, then append or report
//     delete   : scan up to the match, then shift each later entry down
//   requests: one at a time, a new one is taken only when the sequencer is idle
//   reset: i_rst_n low clears the entry count and the sequencer; stored
//   entries are not cleared, since only entries below the count are read
//   stall: the result waits in an output register; a new request is taken
//   meanwhile and its result is held until the output register frees up
// ----------------------------------------------------------------------------
module keyed_accumulate_table #(
    parameter int CAPACITY = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request channel
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_req_type,
    input  logic [kat_pkg::KEY_W-1:0]        i_item_key,
    input  logic [kat_pkg::QTY_IN_W-1:0]     i_item_quantity,
    input  logic [kat_pkg::PRICE_W-1:0]      i_item_price,
    // result channel
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [kat_pkg::STATUS_W-1:0]     o_status,
    output logic [kat_pkg::OUT_CNT_W-1:0]    o_entry_count
);

    // command and status between sequencer and datapath
    kat_pkg::t_ctl_cmd w_cmd;
    kat_pkg::t_ctl_sts w_sts;

    // sequencer: search, then merge, append or shift down
    kat_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // entry memory, counters and result register
    kat_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_req_type      (i_req_type),
        .i_item_key      (i_item_key),
        .i_item_quantity (i_item_quantity),
        .i_item_price    (i_item_price),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_entry_count   (o_entry_count)
    );

endmodule

>>> src/kat_dpath.sv
// ----------------------------------------------------------------------------
// kat_dpath
// entry memory, scan index, entry count and result register
// ----------------------------------------------------------------------------
module kat_dpath #(
    parameter int CAPACITY = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  kat_pkg::t_ctl_cmd                    i_cmd,
    output kat_pkg::t_ctl_sts                    o_sts,
    input  logic                                 i_req_type,
    input  logic [kat_pkg::KEY_W-1:0]            i_item_key,
    input  logic [kat_pkg::QTY_IN_W-1:0]         i_item_quantity,
    input  logic [kat_pkg::PRICE_W-1:0]          i_item_price,
    input  logic                                 i_ready,
    output logic                                 o_valid,
    output logic [kat_pkg::STATUS_W-1:0]         o_status,
    output logic [kat_pkg::OUT_CNT_W-1:0]        o_entry_count
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    kat_pkg::t_entry r_mem [CAPACITY];
    kat_pkg::t_entry r_rd_data;
    kat_pkg::t_entry w_wr_data;

    logic                             r_req_type;
    logic [kat_pkg::KEY_W-1:0]        r_req_key;
    logic [kat_pkg::QTY_IN_W-1:0]     r_req_qty;
    logic [kat_pkg::PRICE_W-1:0]      r_req_price;

    logic [CNT_W-1:0]                 r_idx;
    logic [CNT_W-1:0]                 r_count;
    logic [CNT_W-1:0]                 w_idx_p1;
    logic [IDX_W-1:0]                 w_raddr;
    logic [IDX_W-1:0]                 w_waddr;
    logic                             w_wr_en;
    logic [kat_pkg::QTY_W:0]          w_sum;
    logic [kat_pkg::QTY_W-1:0]        w_sat;
    logic [kat_pkg::STATUS_W-1:0]     r_status;
    logic                             r_out_valid;
    logic [kat_pkg::STATUS_W-1:0]     r_out_status;
    logic [CNT_W+kat_pkg::OUT_CNT_W-1:0] w_cnt_ext;
    logic [kat_pkg::OUT_CNT_W-1:0]    r_out_count;

    assign w_idx_p1 = r_idx + CNT_W'(1);
    assign w_raddr  = i_cmd.rd_next ? w_idx_p1[IDX_W-1:0] : r_idx[IDX_W-1:0];
    assign w_waddr  = i_cmd.wr_append ? r_count[IDX_W-1:0] : r_idx[IDX_W-1:0];
    assign w_wr_en  = i_cmd.wr_merge | i_cmd.wr_append | i_cmd.wr_shift;

    // saturating merge of quantity
    assign w_sum = {1'b0, r_rd_data.qty}
                 + {{(kat_pkg::QTY_W + 1 - kat_pkg::QTY_IN_W){1'b0}}, r_req_qty};
    assign w_sat = w_sum[kat_pkg::QTY_W] ? {kat_pkg::QTY_W{1'b1}}
                                         : w_sum[kat_pkg::QTY_W-1:0];

    always_comb begin
        w_wr_data = r_rd_data;
        if (i_cmd.wr_merge) begin
            w_wr_data.qty   = w_sat;
            w_wr_data.price = r_req_price;
        end else if (i_cmd.wr_append) begin
            w_wr_data.key   = r_req_key;
            w_wr_data.qty   = {{(kat_pkg::QTY_W - kat_pkg::QTY_IN_W){1'b0}}, r_req_qty};
            w_wr_data.price = r_req_price;
        end
    end

    // entry memory: one read and one write port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_waddr] <= w_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    // request latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req_type  <= i_req_type;
            r_req_key   <= i_item_key;
            r_req_qty   <= i_item_quantity;
            r_req_price <= i_item_price;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.clr_idx) begin
                r_idx <= '0;
            end else if (i_cmd.inc_idx) begin
                r_idx <= w_idx_p1;
            end
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // result register
    assign w_cnt_ext = {{kat_pkg::OUT_CNT_W{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_status;
            r_out_count  <= w_cnt_ext[kat_pkg::OUT_CNT_W-1:0];
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_entry_count = r_out_count;

    assign o_sts.req_type   = r_req_type;
    assign o_sts.at_end     = (r_idx == r_count);
    assign o_sts.key_match  = (r_rd_data.key == r_req_key);
    assign o_sts.full       = (r_count == CAP_CNT);
    assign o_sts.shift_last = (w_idx_p1 >= r_count);
    assign o_sts.out_free   = !r_out_valid || i_ready;

endmodule

>>> src/kat_ctrl.sv
// ----------------------------------------------------------------------------
// kat_ctrl
// sequencer for search, merge, append and delete with shift
// ----------------------------------------------------------------------------
module kat_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  kat_pkg::t_ctl_sts i_sts,
    output kat_pkg::t_ctl_cmd o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_CMP    = 3'd2;
    localparam logic [2:0] S_SH_RD  = 3'd3;
    localparam logic [2:0] S_SH_WR  = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load_req = 1'b1;
                    o_cmd.clr_idx  = 1'b1;
                    n_state        = S_READ;
                end
            end
            S_READ: begin
                if (i_sts.at_end) begin
                    // key not present
                    o_cmd.set_status = 1'b1;
                    n_state          = S_FINISH;
                    if (i_sts.req_type == kat_pkg::REQ_DEL) begin
                        o_cmd.status = kat_pkg::ST_NOT_FOUND;
                    end else if (i_sts.full) begin
                        o_cmd.status = kat_pkg::ST_FULL;
                    end else begin
                        o_cmd.status    = kat_pkg::ST_APPENDED;
                        o_cmd.wr_append = 1'b1;
                        o_cmd.cnt_inc   = 1'b1;
                    end
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_CMP;
                end
            end
            S_CMP: begin
                if (i_sts.key_match) begin
                    o_cmd.set_status = 1'b1;
                    if (i_sts.req_type == kat_pkg::REQ_DEL) begin
                        o_cmd.status = kat_pkg::ST_DELETED;
                        n_state      = S_SH_RD;
                    end else begin
                        o_cmd.status   = kat_pkg::ST_MERGED;
                        o_cmd.wr_merge = 1'b1;
                        n_state        = S_FINISH;
                    end
                end else begin
                    o_cmd.inc_idx = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_SH_RD: begin
                if (i_sts.shift_last) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_FINISH;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_next = 1'b1;
                    n_state       = S_SH_WR;
                end
            end
            S_SH_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.inc_idx  = 1'b1;
                n_state        = S_SH_RD;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// checks the keyed accumulate table against a queue-based table model:
// directed corner requests, three random phases with changing idle patterns
// on both channels, and a long result stall that backs up the request side
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CAPACITY    = 16;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 80;      // well above the longest delete scan
    localparam int POOL_SIZE   = 24;      // a bit more keys than entries, so full is hit
    localparam logic [kat_pkg::QTY_W-1:0] QTY_SAT = {kat_pkg::QTY_W{1'b1}};

    // dut ports, all inputs known from time zero
    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_valid = 1'b0;
    logic                            o_ready;
    logic                            i_req_type = kat_pkg::REQ_ADD;
    logic [kat_pkg::KEY_W-1:0]       i_item_key = '0;
    logic [kat_pkg::QTY_IN_W-1:0]    i_item_quantity = '0;
    logic [kat_pkg::PRICE_W-1:0]     i_item_price = '0;
    logic                            o_valid;
    logic                            i_ready = 1'b0;
    logic [kat_pkg::STATUS_W-1:0]    o_status;
    logic [kat_pkg::OUT_CNT_W-1:0]   o_entry_count;

    // shadow copy of the table, kept in stored order
    logic [kat_pkg::KEY_W-1:0]       tbl_keys[$];
    logic [kat_pkg::QTY_W-1:0]       tbl_qtys[$];
    logic [kat_pkg::PRICE_W-1:0]     tbl_prices[$];

    // results still owed by the dut, oldest first
    logic [kat_pkg::STATUS_W-1:0]    exp_status_q[$];
    logic [kat_pkg::OUT_CNT_W-1:0]   exp_count_q[$];

    // idle percentages per channel, changed between phases
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;   // cycles left in a forced result stall
    int fail_count    = 0;
    int cycle_count   = 0;

    logic [kat_pkg::KEY_W-1:0] pool_keys[POOL_SIZE];

    keyed_accumulate_table #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_req_type(i_req_type),
        .i_item_key(i_item_key),
        .i_item_quantity(i_item_quantity),
        .i_item_price(i_item_price),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_status(o_status),
        .o_entry_count(o_entry_count)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, exp_status_q.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // result side ready: forced stall first, else random idling
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // mismatch report, only the first ten are printed
    task automatic report_mismatch(input string what, input int exp_val, input int act_val);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch at cycle %0d: %s expected %0d got %0d",
                     cycle_count, what, exp_val, act_val);
    endtask

    // table model: applies one request and returns status and count
    task automatic predict_table_update(
        input  logic                            req,
        input  logic [kat_pkg::KEY_W-1:0]       key,
        input  logic [kat_pkg::QTY_IN_W-1:0]    qty,
        input  logic [kat_pkg::PRICE_W-1:0]     price,
        output logic [kat_pkg::STATUS_W-1:0]    status,
        output logic [kat_pkg::OUT_CNT_W-1:0]   count
    );
        int                          hit;
        logic [kat_pkg::QTY_W:0]     sum;
        hit = -1;
        // keys are unique, first match is the only match
        foreach (tbl_keys[i]) begin
            if (hit < 0 && tbl_keys[i] == key)
                hit = i;
        end
        if (req == kat_pkg::REQ_ADD) begin
            if (hit >= 0) begin
                // merge: saturating quantity, price overwritten
                sum = {1'b0, tbl_qtys[hit]}
                    + {{(kat_pkg::QTY_W + 1 - kat_pkg::QTY_IN_W){1'b0}}, qty};
                tbl_qtys[hit]   = (sum > {1'b0, QTY_SAT}) ? QTY_SAT
                                                          : sum[kat_pkg::QTY_W-1:0];
                tbl_prices[hit] = price;
                status = kat_pkg::ST_MERGED;
            end else if (tbl_keys.size() >= CAPACITY) begin
                status = kat_pkg::ST_FULL;
            end else begin
                tbl_keys.push_back(key);
                tbl_qtys.push_back(kat_pkg::QTY_W'(qty));
                tbl_prices.push_back(price);
                status = kat_pkg::ST_APPENDED;
            end
        end else begin
            if (hit >= 0) begin
                // queue delete keeps the order of later entries
                tbl_keys.delete(hit);
                tbl_qtys.delete(hit);
                tbl_prices.delete(hit);
                status = kat_pkg::ST_DELETED;
            end else begin
                status = kat_pkg::ST_NOT_FOUND;
            end
        end
        count = kat_pkg::OUT_CNT_W'(tbl_keys.size());
    endtask

    // result checker, compares with the oldest expected result
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (exp_status_q.size() == 0) begin
                report_mismatch("unexpected result, status", -1, int'(o_status));
            end else begin
                if (o_status !== exp_status_q[0])
                    report_mismatch("status", int'(exp_status_q[0]), int'(o_status));
                if (o_entry_count !== exp_count_q[0])
                    report_mismatch("entry count", int'(exp_count_q[0]),
                                    int'(o_entry_count));
                void'(exp_status_q.pop_front());
                void'(exp_count_q.pop_front());
            end
        end
    end

    // sends one request: random gap, then valid held until accepted
    task automatic send_request(
        input logic                           req,
        input logic [kat_pkg::KEY_W-1:0]      key,
        input logic [kat_pkg::QTY_IN_W-1:0]   qty,
        input logic [kat_pkg::PRICE_W-1:0]    price
    );
        int                              gap;
        logic [kat_pkg::STATUS_W-1:0]    st;
        logic [kat_pkg::OUT_CNT_W-1:0]   cnt;
        gap = 0;
        while (gap < 8 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid         <= 1'b1;
        i_req_type      <= req;
        i_item_key      <= key;
        i_item_quantity <= qty;
        i_item_price    <= price;
        do @(posedge i_clk); while (!o_ready);
        // accepted at this edge
        predict_table_update(req, key, qty, price, st, cnt);
        exp_status_q.push_back(st);
        exp_count_q.push_back(cnt);
    endtask

    // random quantity and price, every bit gets both values
    task automatic send_random_fields(input logic req, input logic [kat_pkg::KEY_W-1:0] key);
        send_request(req, key, kat_pkg::QTY_IN_W'($urandom_range(0, 65535)),
                     kat_pkg::PRICE_W'($urandom_range(0, 65535)));
    endtask

    // corner requests: empty table, key and field extremes, fill, full, shifts
    task automatic test_directed_cases();
        send_request(kat_pkg::REQ_DEL, 16'h0000, 16'hFFFF, 16'hFFFF);   // delete on empty
        send_request(kat_pkg::REQ_ADD, 16'h0000, 16'h0000, 16'h0000);   // append lowest key
        send_request(kat_pkg::REQ_ADD, 16'h0000, 16'hFFFF, 16'hFFFF);   // merge, max fields
        send_request(kat_pkg::REQ_ADD, 16'hFFFF, 16'hFFFF, 16'h0000);   // append highest key
        send_request(kat_pkg::REQ_DEL, 16'h0000, 16'h0000, 16'h0000);   // delete head, shift
        send_request(kat_pkg::REQ_DEL, 16'h0000, 16'h1234, 16'h4321);   // now not found
        // fill up to capacity behind the 0xffff entry
        for (int i = 0; i < CAPACITY - 1; i++)
            send_request(kat_pkg::REQ_ADD, kat_pkg::KEY_W'(16'h0100 + i),
                         16'hFFFF, 16'hA5A5);
        send_request(kat_pkg::REQ_ADD, 16'h1234, 16'h0001, 16'h0001);   // new key, full
        send_request(kat_pkg::REQ_ADD, 16'h0105, 16'hFFFF, 16'h5A5A);   // existing key, full
        send_request(kat_pkg::REQ_DEL, 16'h0107, 16'h0000, 16'h0000);   // middle delete
        send_request(kat_pkg::REQ_DEL, 16'h010E, 16'h0000, 16'h0000);   // last entry delete
    endtask

    // random mix; add bias drifts so the table swings between empty and full
    task automatic test_random_mix(input int n_items);
        int r;
        int add_bias;
        add_bias = 50;
        for (int n = 0; n < n_items; n++) begin
            if (n % 50 == 0)
                add_bias = $urandom_range(25, 80);
            r = $urandom_range(0, 99);
            if (r < add_bias) begin
                // mostly pool keys so merges and full hits happen
                if ($urandom_range(0, 9) < 8)
                    send_random_fields(kat_pkg::REQ_ADD,
                                       pool_keys[$urandom_range(0, POOL_SIZE - 1)]);
                else
                    send_random_fields(kat_pkg::REQ_ADD,
                                       kat_pkg::KEY_W'($urandom_range(0, 65535)));
            end else if (r < add_bias + (100 - add_bias) * 3 / 4 && tbl_keys.size() > 0) begin
                // delete of a key that is present, at any position
                send_random_fields(kat_pkg::REQ_DEL,
                                   tbl_keys[$urandom_range(0, tbl_keys.size() - 1)]);
            end else if ($urandom_range(0, 1) == 0) begin
                send_random_fields(kat_pkg::REQ_DEL,
                                   pool_keys[$urandom_range(0, POOL_SIZE - 1)]);
            end else begin
                send_random_fields(kat_pkg::REQ_DEL,
                                   kat_pkg::KEY_W'($urandom_range(0, 65535)));
            end
        end
    endtask

    // long result stall while requests keep coming, input must back up
    task automatic test_output_backpressure();
        send_random_fields(kat_pkg::REQ_ADD, pool_keys[0]);
        hold_left = 300;
        for (int n = 0; n < 20; n++) begin
            if (n % 3 == 2 && tbl_keys.size() > 0)
                send_random_fields(kat_pkg::REQ_DEL,
                                   tbl_keys[$urandom_range(0, tbl_keys.size() - 1)]);
            else
                send_random_fields(kat_pkg::REQ_ADD,
                                   pool_keys[$urandom_range(0, POOL_SIZE - 1)]);
        end
    endtask

    initial begin
        foreach (pool_keys[i])
            pool_keys[i] = kat_pkg::KEY_W'($urandom_range(0, 65535));

        // synchronous reset
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // phase a: sender idles a little, receiver a lot
        send_idle_pct = 19;
        recv_idle_pct = 54;
        test_directed_cases();
        test_random_mix(300);

        // phase b: swapped
        send_idle_pct = 54;
        recv_idle_pct = 19;
        test_random_mix(300);

        // phase c: no idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(300);
        test_output_backpressure();

        @(negedge i_clk);
        i_valid <= 1'b0;

        // drain, then give any stray result time to show up
        while (exp_status_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        fail_count += exp_status_q.size();
        if (fail_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
